// ===== rtl/adsmr_pkg.sv =====
`default_nettype none

package adsmr_pkg;

	// tally and result widths
	localparam int CNT_W     = 20;
	localparam int FRAC_BITS = 16;
	localparam int RATIO_W   = FRAC_BITS + 1;
	localparam int DIV_STEPS = RATIO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int CODE_W    = 8;
	localparam int SET_W     = 4;

	localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	// bit-coded nucleotide codes
	localparam logic [CODE_W-1:0] CODE_A       = 8'h88;
	localparam logic [CODE_W-1:0] CODE_G       = 8'h48;
	localparam logic [CODE_W-1:0] CODE_C       = 8'h28;
	localparam logic [CODE_W-1:0] CODE_T       = 8'h18;
	localparam logic [CODE_W-1:0] CODE_R       = 8'hc0;
	localparam logic [CODE_W-1:0] CODE_M       = 8'ha0;
	localparam logic [CODE_W-1:0] CODE_W_AT    = 8'h90;
	localparam logic [CODE_W-1:0] CODE_S       = 8'h60;
	localparam logic [CODE_W-1:0] CODE_K       = 8'h50;
	localparam logic [CODE_W-1:0] CODE_Y       = 8'h30;
	localparam logic [CODE_W-1:0] CODE_V       = 8'he0;
	localparam logic [CODE_W-1:0] CODE_H       = 8'hb0;
	localparam logic [CODE_W-1:0] CODE_D       = 8'hd0;
	localparam logic [CODE_W-1:0] CODE_B       = 8'h70;
	localparam logic [CODE_W-1:0] CODE_N       = 8'hf0;
	localparam logic [CODE_W-1:0] CODE_GAP     = 8'h04;
	localparam logic [CODE_W-1:0] CODE_MISSING = 8'h02;

	// base set bits
	localparam logic [SET_W-1:0] SET_A = 4'b0001;
	localparam logic [SET_W-1:0] SET_C = 4'b0010;
	localparam logic [SET_W-1:0] SET_G = 4'b0100;
	localparam logic [SET_W-1:0] SET_T = 4'b1000;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic acc_en;   // site beat accepted
		logic div_step; // one quotient bit
		logic out_load; // result into output register
	} cmd_t;

	typedef struct packed {
		logic div_last; // final quotient bit this cycle
	} sts_t;

	function automatic logic [SET_W-1:0] base_set(input logic [CODE_W-1:0] code);
		logic [SET_W-1:0] s;
		unique case (code)
			CODE_A:    s = SET_A;
			CODE_G:    s = SET_G;
			CODE_C:    s = SET_C;
			CODE_T:    s = SET_T;
			CODE_R:    s = SET_A | SET_G;
			CODE_M:    s = SET_A | SET_C;
			CODE_W_AT: s = SET_A | SET_T;
			CODE_S:    s = SET_C | SET_G;
			CODE_K:    s = SET_G | SET_T;
			CODE_Y:    s = SET_C | SET_T;
			CODE_V:    s = SET_A | SET_C | SET_G;
			CODE_H:    s = SET_A | SET_C | SET_T;
			CODE_D:    s = SET_A | SET_G | SET_T;
			CODE_B:    s = SET_C | SET_G | SET_T;
			CODE_N:    s = SET_A | SET_C | SET_G | SET_T;
			default:   s = '0;
		endcase
		return s;
	endfunction

	function automatic logic is_present(input logic [CODE_W-1:0] code);
		return (code != CODE_GAP) && (code != CODE_MISSING);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/adsmr_ctrl.sv =====
`default_nettype none

module adsmr_ctrl
	import adsmr_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	input  wire  s_tlast,
	output logic s_tready,
	output logic m_tvalid,
	input  wire  m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACC;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.acc_en   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_ACC: begin
				s_tready   = 1'b1;
				cmd.acc_en = accept;
				if (accept && s_tlast) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// ===== rtl/adsmr_dpath.sv =====
`default_nettype none

module adsmr_dpath
	import adsmr_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [2*CODE_W-1:0]     site,
	input  wire                     site_last,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic [CNT_W-1:0]        comp_cnt,
	output logic [CNT_W-1:0]        valid_cnt,
	output logic [RATIO_W-1:0]      ratio,
	output logic                    zero_valid
);

	logic [CNT_W-1:0]   comp_tally_q, valid_tally_q;
	logic [CNT_W-1:0]   comp_next, valid_next;
	logic [CNT_W-1:0]   comp_res_q, valid_res_q;
	logic [CNT_W:0]     rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W:0]     rem_diff;
	logic               q_bit;
	logic [CNT_W:0]     rem_kept;
	logic [CNT_W-1:0]   comp_out_q, valid_out_q;
	logic [RATIO_W-1:0] ratio_out_q;
	logic               zero_out_q;
	logic               hit_comp, hit_valid;
	logic [CODE_W-1:0]  code_a, code_b;

	assign code_a = site[CODE_W-1:0];
	assign code_b = site[2*CODE_W-1:CODE_W];

	assign hit_comp  = |(base_set(code_a) & base_set(code_b));
	assign hit_valid = is_present(code_a) && is_present(code_b);

	assign comp_next  = (hit_comp && comp_tally_q != CNT_MAX) ?
		comp_tally_q + 1'b1 : comp_tally_q;
	assign valid_next = (hit_valid && valid_tally_q != CNT_MAX) ?
		valid_tally_q + 1'b1 : valid_tally_q;

	// tallies, cleared after the last site
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_tally_q  <= '0;
			valid_tally_q <= '0;
			step_q        <= '0;
		end else begin
			if (cmd.acc_en) begin
				if (site_last) begin
					comp_tally_q  <= '0;
					valid_tally_q <= '0;
					step_q        <= '0;
				end else begin
					comp_tally_q  <= comp_next;
					valid_tally_q <= valid_next;
				end
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// restoring divider, MSB first; compatible never exceeds valid
	assign rem_diff = rem_q - {1'b0, valid_res_q};
	assign q_bit    = rem_q >= {1'b0, valid_res_q};
	assign rem_kept = q_bit ? rem_diff : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_en && site_last) begin
			comp_res_q  <= comp_next;
			valid_res_q <= valid_next;
			rem_q       <= {1'b0, comp_next};
			quo_q       <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {rem_kept[CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], q_bit};
		end
	end

	assign sts.div_last = (step_q == STEP_LAST);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			comp_out_q  <= comp_res_q;
			valid_out_q <= valid_res_q;
			zero_out_q  <= (valid_res_q == '0);
			ratio_out_q <= (valid_res_q == '0) ? '0 : quo_q;
		end
	end

	assign comp_cnt   = comp_out_q;
	assign valid_cnt  = valid_out_q;
	assign ratio      = ratio_out_q;
	assign zero_valid = zero_out_q;

endmodule

`default_nettype wire

// ===== rtl/ambiguous_dna_site_match_ratio.sv =====
`default_nettype none

// Pairwise identity over an alignment of bit-coded ambiguous nucleotides.
// Each input beat is one aligned site: two IUPAC-coded bytes. Sites whose
// base sets overlap count as compatible; sites with no gap (0x04) or missing
// (0x02) byte count as valid. Unlisted codes are valid but never compatible.
// Both 20-bit tallies saturate. The beat with s_tlast set is counted, then
// one result beat carries both counts and floor(compatible*65536/valid) as
// unsigned Q1.16; m_tuser flags zero valid sites, with the ratio forced to 0.
// Tallies clear after the last site. Rate: one site per cycle while
// accumulating; a last site stalls the input while the shared bit-per-cycle
// restoring divider runs and the result is loaded into the output register,
// longer only if the previous result is still held there.

module ambiguous_dna_site_match_ratio
	import adsmr_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [7:0] base_first, [15:8] base_second
	input  wire         s_tlast,  // last_site
	output logic        m_tvalid,
	input  wire         m_tready,
	// [19:0] compatible_count, [39:20] valid_count, [56:40] ratio_q16, [63:57] zero
	output logic [63:0] m_tdata,
	output logic        m_tuser   // zero_valid
);

	localparam int PAD_W = 64 - 2*CNT_W - RATIO_W;

	cmd_t               cmd;
	sts_t               sts;
	logic [CNT_W-1:0]   comp_cnt, valid_cnt;
	logic [RATIO_W-1:0] ratio;
	logic               zero_valid;

	adsmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	adsmr_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.site       (s_tdata),
		.site_last  (s_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.comp_cnt   (comp_cnt),
		.valid_cnt  (valid_cnt),
		.ratio      (ratio),
		.zero_valid (zero_valid)
	);

	assign m_tdata = {{PAD_W{1'b0}}, ratio, valid_cnt, comp_cnt};
	assign m_tuser = zero_valid;

`ifndef SYNTHESIS
	// a compatible site is always a valid site
	a_comp_le_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:0] <= m_tdata[39:20]))
		else $error("compatible count above valid count");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[56:40] <= 17'd65536))
		else $error("ratio above one");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[39:20] == '0 && m_tdata[56:40] == '0))
		else $error("zero_valid with nonzero valid count or ratio");

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_tready)
		else $error("input accepted during division");
`endif

endmodule

`default_nettype wire
